// ===== rtl/core/srsw_pkg.sv =====
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int SeqW    = 16;
  localparam int QDepth  = 2;

  // Input op codes, as carried in the low bits of the slave-side tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_NACK  = 2'd2;
  localparam logic [1:0] OP_DATA  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_WINDOW_SIZE  = 1'b0;
  localparam logic CFG_TOTAL_FRAMES = 1'b1;

  localparam logic [4:0] WindowSizeReset = 5'd4;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_END    = 2'd2,
    KIND_REPORT = 2'd3
  } order_kind_e;

  typedef enum logic [2:0] {
    ST_STARTED    = 3'd0,
    ST_ACKED      = 3'd1,
    ST_ACK_IGN    = 3'd2,
    ST_NACKED     = 3'd3,
    ST_NACK_IGN   = 3'd4,
    ST_COMPLETE   = 3'd5,
    ST_UNEXPECTED = 3'd6
  } status_e;

  // Orders other than the report carry a zero status field.
  localparam status_e STATUS_NONE = ST_STARTED;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_ACK,
    CMD_END_ACK,
    CMD_NACK,
    CMD_DATA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [SeqW-1:0] seq;
  } cmd_t;

  typedef struct packed {
    order_kind_e     kind;
    logic [SeqW-1:0] seq;
    status_e         status;
    logic            last;
  } order_t;

  typedef struct packed {
    logic            we;
    logic            index;
    logic [SeqW-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SLIDE,
    BK_RETX,
    BK_NEW,
    BK_END,
    BK_REPORT
  } back_state_e;

endpackage

// ===== rtl/core/srsw_front.sv =====
`timescale 1ns / 1ps

module srsw_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 in_op_i,
  input  logic                       in_end_marker_i,
  input  logic [srsw_pkg::SeqW-1:0]  in_seq_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output srsw_pkg::cmd_t             cmd_o
);
  import srsw_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.seq = in_seq_i;
    unique case (in_op_i)
      OP_START: cmd_o.kind = CMD_START;
      OP_ACK:   cmd_o.kind = in_end_marker_i ? CMD_END_ACK : CMD_ACK;
      OP_NACK:  cmd_o.kind = CMD_NACK;
      default:  cmd_o.kind = CMD_DATA;
    endcase
  end

endmodule

// ===== rtl/core/srsw_queue.sv =====
`timescale 1ns / 1ps

module srsw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srsw_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           head_valid_o,
  output srsw_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import srsw_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  cmd_t            entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (count_q == CntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/srsw_back.sv =====
`timescale 1ns / 1ps

module srsw_back #(
  parameter int WINDOW_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srsw_pkg::cfg_wr_t cfg_i,
  input  logic              head_valid_i,
  input  srsw_pkg::cmd_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srsw_pkg::order_t  out_o
);
  import srsw_pkg::*;

  localparam int SlotW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  back_state_e      state_q, state_d;
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  next_q, next_d;
  logic [SeqW-1:0]  iter_q, iter_d;
  logic [SlotW-1:0] base_slot_q, base_slot_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic [SlotW-1:0] iter_slot_q, iter_slot_d;
  logic [WINDOW_MAX-1:0] marks_q, marks_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [4:0]       window_size_q;
  logic [SeqW-1:0]  total_q;

  logic             out_valid_q;
  order_t           out_q;
  logic             can_load, load;
  order_t           load_order;

  logic [SeqW-1:0]  offset;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] head_slot;
  logic             in_win, at_base;
  logic [SeqW:0]    eff;
  logic [SeqW:0]    limit;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == SlotW'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
  endfunction

  // The sent window never spans more than WINDOW_MAX frames, so the slot of an
  // in-window frame is the base slot plus a short offset, folded once.
  always_comb begin
    offset    = head_i.seq - base_q;
    slot_sum  = {1'b0, base_slot_q} + {1'b0, offset[SlotW-1:0]};
    head_slot = (slot_sum >= (SlotW+1)'(WINDOW_MAX)) ?
                SlotW'(slot_sum - (SlotW+1)'(WINDOW_MAX)) : SlotW'(slot_sum);
    in_win    = (head_i.seq >= base_q) && (head_i.seq < next_q);
    at_base   = (head_i.seq == base_q);
    if (window_size_q == '0) begin
      eff = (SeqW+1)'(1);
    end else if (32'(window_size_q) > WINDOW_MAX) begin
      eff = (SeqW+1)'(WINDOW_MAX);
    end else begin
      eff = (SeqW+1)'(window_size_q);
    end
    limit = {1'b0, base_q} + eff;
  end

  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    iter_d      = iter_q;
    base_slot_d = base_slot_q;
    next_slot_d = next_slot_q;
    iter_slot_d = iter_slot_q;
    marks_d     = marks_q;
    done_d      = done_q;
    status_d    = status_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    load_order  = '{kind: KIND_REPORT, seq: base_q, status: status_q, last: 1'b0};

    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_REPORT;
          unique case (head_i.kind)
            CMD_START: begin
              base_d      = '0;
              next_d      = '0;
              base_slot_d = '0;
              next_slot_d = '0;
              iter_d      = '0;
              iter_slot_d = '0;
              marks_d     = '0;
              done_d      = 1'b0;
              status_d    = ST_STARTED;
              state_d     = BK_RETX;
            end
            CMD_END_ACK: begin
              if (head_i.seq >= total_q) begin
                done_d   = 1'b1;
                status_d = ST_COMPLETE;
              end else begin
                status_d = ST_ACK_IGN;
              end
            end
            CMD_ACK: begin
              if (done_q || !in_win) begin
                status_d = ST_ACK_IGN;
              end else begin
                status_d = ST_ACKED;
                if (!marks_q[head_slot]) begin
                  marks_d[head_slot] = 1'b1;
                  if (at_base) begin
                    state_d = BK_SLIDE;
                  end
                end
              end
            end
            CMD_NACK: begin
              if (done_q || !in_win) begin
                status_d = ST_NACK_IGN;
              end else begin
                status_d = ST_NACKED;
                if (at_base) begin
                  iter_d      = base_q;
                  iter_slot_d = base_slot_q;
                  state_d     = BK_RETX;
                end
              end
            end
            default: begin
              status_d = ST_UNEXPECTED;
            end
          endcase
        end
      end

      BK_SLIDE: begin
        if ((base_q < next_q) && marks_q[base_slot_q]) begin
          marks_d[base_slot_q] = 1'b0;
          base_d      = base_q + 1'b1;
          base_slot_d = slot_inc(base_slot_q);
        end else begin
          iter_d      = base_q;
          iter_slot_d = base_slot_q;
          state_d     = BK_RETX;
        end
      end

      BK_RETX: begin
        if (iter_q < next_q) begin
          if (marks_q[iter_slot_q]) begin
            iter_d      = iter_q + 1'b1;
            iter_slot_d = slot_inc(iter_slot_q);
          end else if (can_load) begin
            load        = 1'b1;
            load_order  = '{kind: KIND_RETX, seq: iter_q, status: STATUS_NONE, last: 1'b0};
            iter_d      = iter_q + 1'b1;
            iter_slot_d = slot_inc(iter_slot_q);
          end
        end else begin
          state_d = BK_NEW;
        end
      end

      BK_NEW: begin
        if ((next_q < total_q) && ({1'b0, next_q} < limit)) begin
          if (can_load) begin
            load                 = 1'b1;
            load_order           = '{kind: KIND_SEND, seq: next_q, status: STATUS_NONE,
                                     last: 1'b0};
            marks_d[next_slot_q] = 1'b0;
            next_d               = next_q + 1'b1;
            next_slot_d          = slot_inc(next_slot_q);
          end
        end else begin
          state_d = BK_END;
        end
      end

      BK_END: begin
        if (base_q >= total_q) begin
          if (can_load) begin
            load       = 1'b1;
            load_order = '{kind: KIND_END, seq: base_q, status: STATUS_NONE, last: 1'b0};
            state_d    = BK_REPORT;
          end
        end else begin
          state_d = BK_REPORT;
        end
      end

      BK_REPORT: begin
        if (can_load) begin
          load       = 1'b1;
          load_order = '{kind: KIND_REPORT, seq: base_q, status: status_q, last: 1'b1};
          state_d    = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      iter_q      <= '0;
      base_slot_q <= '0;
      next_slot_q <= '0;
      iter_slot_q <= '0;
      marks_q     <= '0;
      done_q      <= 1'b0;
      status_q    <= ST_STARTED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      iter_q      <= iter_d;
      base_slot_q <= base_slot_d;
      next_slot_q <= next_slot_d;
      iter_slot_q <= iter_slot_d;
      marks_q     <= marks_d;
      done_q      <= done_d;
      status_q    <= status_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= load_order;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WindowSizeReset;
      total_q       <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        CFG_WINDOW_SIZE:  window_size_q <= cfg_i.data[4:0];
        default:          total_q       <= cfg_i.data;
      endcase
    end
  end

endmodule

// ===== rtl/core/selective_repeat_sender_window_core.sv =====
// Sender-side window controller for selective repeat. Each transfer on the slave
// stream is a start, an ack, a nack or an unexpected data frame; each one causes
// a run of orders on the master stream (new sends, retransmits, an end notice)
// that always closes with a status report marked by tlast. Received items pass
// through a two-entry queue into a single window engine, so the input side keeps
// taking items while the engine works, as long as the queue has room. An item
// that orders nothing but the report goes straight to it. An ack at the base
// first slides the base past the acked frames, then walks the frames still
// outstanding for retransmits, then issues new sends, then makes the end check
// and last the report. The engine walks the window one slot per cycle; a
// stalled master side holds the walk. Window size and total frame count are
// written through the configuration channel, which is always ready.
`timescale 1ns / 1ps

module selective_repeat_sender_window_core #(
  parameter int WINDOW_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes: index 0 window_size, index 1 total_frames.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Received frames.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] seq_number
  input  logic [2:0]  s_axis_tuser,   // [1:0] op, [2] end_marker
  // Orders.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] order_seq, [18:16] status_code, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] order_kind
  output logic        m_axis_tlast    // last_of_run
);
  import srsw_pkg::*;

  cfg_wr_t cfg_wr;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  order_t  order;
  logic    push, q_full, head_valid, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{we: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  srsw_front u_front (
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_op_i         (s_axis_tuser[1:0]),
    .in_end_marker_i (s_axis_tuser[2]),
    .in_seq_i        (s_axis_tdata),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  srsw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (front_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_cmd),
    .pop_i        (pop)
  );

  srsw_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (order)
  );

  assign m_axis_tdata = {5'b0, order.status, order.seq};
  assign m_axis_tuser = order.kind;
  assign m_axis_tlast = order.last;

endmodule

// ===== rtl/core/srsw_checker.sv =====
`timescale 1ns / 1ps

module srsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import srsw_pkg::*;

  // An order held back by the consumer stays as it was.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("order changed while stalled");

  // Exactly the status report closes a run.
  a_last_is_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_REPORT)))
    else $error("tlast does not mark the status report");

  a_report_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPORT) |-> (m_axis_tdata[18:16] != 3'd7))
    else $error("status report carries an undefined code");

  a_order_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_REPORT) |->
      (m_axis_tdata[18:16] == 3'd0) && (m_axis_tdata[23:19] == 5'd0))
    else $error("send order carries a status field");

endmodule

bind selective_repeat_sender_window_core srsw_checker u_srsw_checker (.*);
